[rtl/core/gkt_pkg.sv]
// Shared types, constants and key binding tables of the gamepad key translator.
`default_nettype none
package gkt_pkg;

    localparam int BUTTONS     = 17;
    localparam int AXIS_SRC    = 6;
    localparam int SRC_N       = AXIS_SRC + BUTTONS;
    localparam int IDX_W       = $clog2(SRC_N);
    localparam int KEY_CODES   = 256;
    localparam int KEY_W       = $clog2(KEY_CODES);
    localparam int CNT_W       = 3;
    localparam int MAX_EVENTS  = 40;
    localparam int EVCNT_W     = $clog2(MAX_EVENTS + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int AXIS_LEV_W  = 15;
    localparam int TRIG_LEV_W  = 16;

    localparam logic [CNT_W-1:0] HOLD_MAX = 3'd7;

    localparam logic [AXIS_LEV_W-1:0] AXIS_PRESS_RST    = 15'd11469;
    localparam logic [AXIS_LEV_W-1:0] AXIS_RELEASE_RST  = 15'd8192;
    localparam logic [TRIG_LEV_W-1:0] TRIG_PRESS_RST    = 16'd11469;
    localparam logic [TRIG_LEV_W-1:0] TRIG_RELEASE_RST  = 16'd8192;

    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_PRESS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_RELEASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_PRESS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_RELEASE = 2'd3;

    localparam logic CMD_FRAME      = 1'b0;
    localparam logic CMD_DISCONNECT = 1'b1;

    localparam logic [KEY_W-1:0] K_NONE      = 8'h00;
    localparam logic [KEY_W-1:0] K_RIGHT     = 8'hAE;
    localparam logic [KEY_W-1:0] K_LEFT      = 8'hAC;
    localparam logic [KEY_W-1:0] K_UP        = 8'hAD;
    localparam logic [KEY_W-1:0] K_DOWN      = 8'hAF;
    localparam logic [KEY_W-1:0] K_STRAFE_L  = 8'hA0;
    localparam logic [KEY_W-1:0] K_STRAFE_R  = 8'hA1;
    localparam logic [KEY_W-1:0] K_USE       = 8'hA2;
    localparam logic [KEY_W-1:0] K_FIRE      = 8'hA3;
    localparam logic [KEY_W-1:0] K_ESC       = 8'd27;
    localparam logic [KEY_W-1:0] K_ENTER     = 8'd13;
    localparam logic [KEY_W-1:0] K_TAB       = 8'd9;
    localparam logic [KEY_W-1:0] K_BACKSPACE = 8'h7F;
    localparam logic [KEY_W-1:0] K_RSHIFT    = 8'hB6;
    localparam logic [KEY_W-1:0] K_LALT      = 8'hB8;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_DECIDE,
        ST_SRC,
        ST_RD,
        ST_UPD,
        ST_ADV,
        ST_SW_RD,
        ST_SW_LD,
        ST_SW_EM,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic capture;
        logic set_active;
        logic rel_mode;
        logic idx_clr;
        logic idx_inc;
        logic src_apply;
        logic key_rd;
        logic key_upd;
        logic sw_rd;
        logic sw_load;
        logic sw_step;
        logic sw_next;
        logic addr_clr;
        logic flush;
    } dp_cmd_t;

    typedef struct packed {
        logic rel_needed;
        logic frame_go;
        logic idx_last;
        logic src_op;
        logic cnt_zero;
        logic addr_last;
        logic ev_ok;
        logic upd_emits;
    } dp_stat_t;

    function automatic logic [KEY_W-1:0] neg_key(input logic [1:0] i);
        logic [KEY_W-1:0] k;
        unique case (i)
            2'd0:    k = K_STRAFE_L;
            2'd1:    k = K_UP;
            2'd2:    k = K_LEFT;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] pos_key(input logic [1:0] i);
        logic [KEY_W-1:0] k;
        unique case (i)
            2'd0:    k = K_STRAFE_R;
            2'd1:    k = K_DOWN;
            2'd2:    k = K_RIGHT;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] trig_key(input logic t);
        return t ? K_FIRE : K_LALT;
    endfunction

    function automatic logic [KEY_W-1:0] button_key(input logic [4:0] b);
        logic [KEY_W-1:0] k;
        unique case (b)
            5'd0:    k = K_USE;
            5'd1:    k = K_BACKSPACE;
            5'd2:    k = K_ENTER;
            5'd3:    k = K_TAB;
            5'd4:    k = K_RSHIFT;
            5'd5:    k = K_LALT;
            5'd8:    k = K_TAB;
            5'd9:    k = K_ESC;
            5'd10:   k = K_RSHIFT;
            5'd11:   k = K_FIRE;
            5'd12:   k = K_UP;
            5'd13:   k = K_DOWN;
            5'd14:   k = K_LEFT;
            5'd15:   k = K_RIGHT;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

[rtl/core/gamepad_to_key_event_translator.sv]
// Top level of the gamepad to key event translator.
// Operation: a frame walks the 23 sources, with a hold-count update for each key that
//   changes; a pad change or disconnect adds a release walk of the sources and a
//   256-entry sweep of the hold counts that emits a release for each count still held.
// Throughput: one item at a time; the next is taken once the last event is queued.
// Reset (aresetn low, synchronous) clears held state, sets no active pad, and
//   starts a pass zeroing all 256 hold counts; s_ready stays low until done.
`default_nettype none
module gamepad_to_key_event_translator #(
    parameter int PADS = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration write port
    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_wr_data,
    // input items
    input  wire logic               s_valid,
    output      logic               s_ready,
    input  wire logic               s_cmd,
    input  wire logic signed [2:0]  s_pad_index,
    input  wire logic [1:0]         s_axis_count,
    input  wire logic [4:0]         s_button_count,
    input  wire logic signed [15:0] s_stick_left_x,
    input  wire logic signed [15:0] s_stick_left_y,
    input  wire logic signed [15:0] s_stick_right_x,
    input  wire logic [16:0]        s_button_bits,
    input  wire logic [15:0]        s_left_trigger_level,
    input  wire logic [15:0]        s_right_trigger_level,
    // key events
    output      logic               m_valid,
    input  wire logic               m_ready,
    output      logic               m_key_pressed,
    output      logic [7:0]         m_key_code,
    output      logic               m_last
);
    gkt_pkg::dp_cmd_t  cmd;
    gkt_pkg::dp_stat_t stat;

    // Sequencer: clearing pass, pad decision, source walk, release sweep, flush.
    gkt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // Datapath: thresholds, held flags, hold-count RAM, event holding stage
    // and the output register that decouples the event consumer.
    gkt_datapath #(
        .PADS (PADS)
    ) u_dp (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_wr_en             (cfg_wr_en),
        .cfg_index             (cfg_index),
        .cfg_wr_data           (cfg_wr_data),
        .s_cmd                 (s_cmd),
        .s_pad_index           (s_pad_index),
        .s_axis_count          (s_axis_count),
        .s_button_count        (s_button_count),
        .s_stick_left_x        (s_stick_left_x),
        .s_stick_left_y        (s_stick_left_y),
        .s_stick_right_x       (s_stick_right_x),
        .s_button_bits         (s_button_bits),
        .s_left_trigger_level  (s_left_trigger_level),
        .s_right_trigger_level (s_right_trigger_level),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_key_pressed         (m_key_pressed),
        .m_key_code            (m_key_code),
        .m_last                (m_last),
        .cmd                   (cmd),
        .stat                  (stat)
    );
endmodule
`default_nettype wire

[rtl/core/gkt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gkt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end
endmodule
`default_nettype wire

[rtl/core/gkt_datapath.sv]
// Datapath: input capture, hysteresis evaluation, hold-count RAM and event output.
`default_nettype none
module gkt_datapath #(
    parameter int PADS = 4
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [gkt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [gkt_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  wire logic                              s_cmd,
    input  wire logic signed [2:0]                 s_pad_index,
    input  wire logic [1:0]                        s_axis_count,
    input  wire logic [4:0]                        s_button_count,
    input  wire logic signed [15:0]                s_stick_left_x,
    input  wire logic signed [15:0]                s_stick_left_y,
    input  wire logic signed [15:0]                s_stick_right_x,
    input  wire logic [16:0]                       s_button_bits,
    input  wire logic [15:0]                       s_left_trigger_level,
    input  wire logic [15:0]                       s_right_trigger_level,
    output      logic                              m_valid,
    input  wire logic                              m_ready,
    output      logic                              m_key_pressed,
    output      logic [7:0]                        m_key_code,
    output      logic                              m_last,
    input  wire gkt_pkg::dp_cmd_t                  cmd,
    output      gkt_pkg::dp_stat_t                 stat
);
    localparam int KW = gkt_pkg::KEY_W;
    localparam int CW = gkt_pkg::CNT_W;
    localparam int IW = gkt_pkg::IDX_W;
    localparam int EW = gkt_pkg::EVCNT_W;

    // status to the controller
    logic rel_needed, frame_go, idx_last, src_op;
    logic cnt_zero, addr_last, ev_ok, upd_emits;

    assign stat = '{rel_needed: rel_needed, frame_go: frame_go, idx_last: idx_last,
                    src_op: src_op, cnt_zero: cnt_zero, addr_last: addr_last,
                    ev_ok: ev_ok, upd_emits: upd_emits};

    // configuration
    logic [gkt_pkg::AXIS_LEV_W-1:0] axis_press_reg, axis_release_reg;
    logic [gkt_pkg::TRIG_LEV_W-1:0] trig_press_reg, trig_release_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_press_reg   <= gkt_pkg::AXIS_PRESS_RST;
            axis_release_reg <= gkt_pkg::AXIS_RELEASE_RST;
            trig_press_reg   <= gkt_pkg::TRIG_PRESS_RST;
            trig_release_reg <= gkt_pkg::TRIG_RELEASE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                gkt_pkg::CFG_AXIS_PRESS:   axis_press_reg   <= cfg_wr_data[14:0];
                gkt_pkg::CFG_AXIS_RELEASE: axis_release_reg <= cfg_wr_data[14:0];
                gkt_pkg::CFG_TRIG_PRESS:   trig_press_reg   <= cfg_wr_data;
                gkt_pkg::CFG_TRIG_RELEASE: trig_release_reg <= cfg_wr_data;
                default:                   trig_release_reg <= trig_release_reg;
            endcase
        end
    end

    // captured item
    logic               in_cmd_reg;
    logic signed [2:0]  in_pad_reg;
    logic [1:0]         in_axc_reg;
    logic [4:0]         in_btc_reg;
    logic signed [15:0] in_axis_reg [3];
    logic [16:0]        in_bits_reg;
    logic [15:0]        in_tlev_reg [2];

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_cmd_reg     <= s_cmd;
            in_pad_reg     <= s_pad_index;
            in_axc_reg     <= s_axis_count;
            in_btc_reg     <= s_button_count;
            in_axis_reg[0] <= s_stick_left_x;
            in_axis_reg[1] <= s_stick_left_y;
            in_axis_reg[2] <= s_stick_right_x;
            in_bits_reg    <= s_button_bits;
            in_tlev_reg[0] <= s_left_trigger_level;
            in_tlev_reg[1] <= s_right_trigger_level;
        end
    end

    // pad decision
    logic signed [2:0] active_reg, active_next;
    logic              pad_ok;

    always_comb begin
        pad_ok = !in_pad_reg[2] && (int'({1'b0, in_pad_reg[1:0]}) < PADS);
        active_next = 3'sd0 - 3'sd1;
        rel_needed  = 1'b0;
        frame_go    = 1'b0;
        if (in_cmd_reg == gkt_pkg::CMD_DISCONNECT) begin
            rel_needed  = (in_pad_reg == active_reg);
            active_next = rel_needed ? (3'sd0 - 3'sd1) : active_reg;
        end else if (!pad_ok) begin
            rel_needed = (active_reg != (3'sd0 - 3'sd1));
        end else begin
            rel_needed  = (active_reg != in_pad_reg);
            frame_go    = 1'b1;
            active_next = in_pad_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 3'sd0 - 3'sd1;
        end else if (cmd.set_active) begin
            active_reg <= active_next;
        end
    end

    // source walk
    logic [IW-1:0]  idx_reg;
    logic [5:0]     axis_held_reg;
    logic [1:0]     trig_held_reg;
    logic [16:0]    button_held_reg;
    logic [IW-1:0]  slot;
    logic [IW-1:0]  rj;
    logic [4:0]     b;
    logic [1:0]     ax;
    logic           was, now;
    logic [KW-1:0]  src_key;
    logic signed [16:0] v17, lev17;
    logic [15:0]    tlev, thr;
    logic           dig;

    always_comb begin
        // release order: axes, triggers, then the remaining buttons
        rj = idx_reg - IW'(gkt_pkg::AXIS_SRC);
        slot = idx_reg;
        if (cmd.rel_mode && idx_reg >= IW'(gkt_pkg::AXIS_SRC)) begin
            if (rj < IW'(2)) begin
                slot = rj + IW'(12);
            end else if (rj < IW'(8)) begin
                slot = rj + IW'(4);
            end else begin
                slot = idx_reg;
            end
        end
        b     = 5'(slot - IW'(gkt_pkg::AXIS_SRC));
        ax    = slot[2:1];
        v17   = '0;
        lev17 = '0;
        tlev  = '0;
        thr   = '0;
        dig   = (b < in_btc_reg) && in_bits_reg[b];
        if (slot < IW'(gkt_pkg::AXIS_SRC)) begin
            was   = axis_held_reg[slot[2:0]];
            v17   = (ax < in_axc_reg) ? 17'(in_axis_reg[ax]) : '0;
            lev17 = {2'b00, (was ? axis_release_reg : axis_press_reg)};
            now   = slot[0] ? (v17 > lev17) : (v17 < -lev17);
            src_key = slot[0] ? gkt_pkg::pos_key(ax) : gkt_pkg::neg_key(ax);
        end else if (b == 5'd6 || b == 5'd7) begin
            was     = trig_held_reg[b[0]];
            tlev    = (b < in_btc_reg) ? in_tlev_reg[b[0]] : '0;
            thr     = was ? trig_release_reg : trig_press_reg;
            now     = dig || (tlev > thr);
            src_key = gkt_pkg::trig_key(b[0]);
        end else begin
            was     = button_held_reg[b];
            now     = dig;
            src_key = gkt_pkg::button_key(b);
        end
        if (cmd.rel_mode) begin
            now = 1'b0;
        end
        src_op   = (was != now) && (src_key != gkt_pkg::K_NONE);
        idx_last = (idx_reg == IW'(gkt_pkg::SRC_N - 1));
    end

    logic [KW-1:0] op_key_reg;
    logic          op_down_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg         <= '0;
            axis_held_reg   <= '0;
            trig_held_reg   <= '0;
            button_held_reg <= '0;
        end else begin
            if (cmd.idx_clr) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + IW'(1);
            end
            if (cmd.src_apply) begin
                if (slot < IW'(gkt_pkg::AXIS_SRC)) begin
                    axis_held_reg[slot[2:0]] <= now;
                end else if (b == 5'd6 || b == 5'd7) begin
                    trig_held_reg[b[0]] <= now;
                end else begin
                    button_held_reg[b] <= now;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.src_apply) begin
            op_key_reg  <= src_key;
            op_down_reg <= now;
        end
    end

    // hold counts
    logic [KW-1:0] addr_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] rd_data, new_cnt;
    logic          ram_we, ram_re;
    logic [KW-1:0] ram_waddr, ram_raddr;
    logic [CW-1:0] ram_wdata;

    always_comb begin
        if (op_down_reg) begin
            upd_emits = (rd_data == '0);
            new_cnt = (rd_data == gkt_pkg::HOLD_MAX) ? rd_data : rd_data + CW'(1);
        end else begin
            upd_emits = (rd_data == CW'(1));
            new_cnt = (rd_data == '0) ? rd_data : rd_data - CW'(1);
        end
        ram_we    = cmd.key_upd || cmd.sw_next;
        ram_waddr = cmd.key_upd ? op_key_reg : addr_reg;
        ram_wdata = cmd.key_upd ? new_cnt : '0;
        ram_re    = cmd.key_rd || cmd.sw_rd;
        ram_raddr = cmd.key_rd ? op_key_reg : addr_reg;
        cnt_zero  = (cnt_reg == '0);
        addr_last = (addr_reg == KW'(gkt_pkg::KEY_CODES - 1));
    end

    gkt_ram #(
        .WIDTH (CW),
        .DEPTH (gkt_pkg::KEY_CODES)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= '0;
        end else if (cmd.addr_clr) begin
            addr_reg <= '0;
        end else if (cmd.sw_next) begin
            addr_reg <= addr_reg + KW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sw_load) begin
            cnt_reg <= rd_data;
        end else if (cmd.sw_step) begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    // events: one held back so the final one can carry the last flag
    logic                           pend_valid_reg;
    logic                           pend_pressed_reg;
    logic [KW-1:0]                  pend_code_reg;
    logic [EW-1:0]                  ev_cnt_reg;
    logic                           m_valid_reg;
    logic                           ev_push, ev_take, ev_pressed, out_free, out_load;
    logic [KW-1:0]                  ev_code;

    always_comb begin
        ev_push    = (cmd.key_upd && upd_emits) || cmd.sw_step;
        ev_take    = ev_push && (ev_cnt_reg < EW'(gkt_pkg::MAX_EVENTS));
        ev_pressed = cmd.key_upd ? op_down_reg : 1'b0;
        ev_code    = cmd.key_upd ? op_key_reg : addr_reg;
        out_free   = !m_valid_reg || m_ready;
        ev_ok      = !pend_valid_reg || out_free;
        out_load   = pend_valid_reg && (ev_take || cmd.flush);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            ev_cnt_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.flush) begin
                pend_valid_reg <= 1'b0;
                ev_cnt_reg     <= '0;
            end else if (ev_take) begin
                pend_valid_reg <= 1'b1;
                ev_cnt_reg     <= ev_cnt_reg + EW'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ev_take) begin
            pend_pressed_reg <= ev_pressed;
            pend_code_reg    <= ev_code;
        end
        if (out_load) begin
            m_key_pressed <= pend_pressed_reg;
            m_key_code    <= pend_code_reg;
            m_last        <= cmd.flush;
        end
    end

    assign m_valid = m_valid_reg;
endmodule
`default_nettype wire

[rtl/core/gkt_ctrl.sv]
// Controller state machine sequencing the translator datapath.
`default_nettype none
module gkt_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output      logic              s_ready,
    output      gkt_pkg::dp_cmd_t  cmd,
    input  wire gkt_pkg::dp_stat_t stat
);
    gkt_pkg::state_t state_reg, state_next;
    logic            mode_reg, mode_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gkt_pkg::ST_CLR;
            mode_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        cmd          = '0;
        cmd.rel_mode = mode_reg;
        s_ready      = 1'b0;
        unique case (state_reg)
            gkt_pkg::ST_CLR: begin
                cmd.sw_next = 1'b1;
                if (stat.addr_last) begin
                    state_next = gkt_pkg::ST_IDLE;
                end
            end
            gkt_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = gkt_pkg::ST_DECIDE;
                end
            end
            gkt_pkg::ST_DECIDE: begin
                cmd.set_active = 1'b1;
                cmd.idx_clr    = 1'b1;
                cmd.addr_clr   = 1'b1;
                if (stat.rel_needed) begin
                    mode_next  = 1'b1;
                    state_next = gkt_pkg::ST_SRC;
                end else if (stat.frame_go) begin
                    mode_next  = 1'b0;
                    state_next = gkt_pkg::ST_SRC;
                end else begin
                    state_next = gkt_pkg::ST_FLUSH;
                end
            end
            gkt_pkg::ST_SRC: begin
                cmd.src_apply = 1'b1;
                state_next = stat.src_op ? gkt_pkg::ST_RD : gkt_pkg::ST_ADV;
            end
            gkt_pkg::ST_RD: begin
                cmd.key_rd = 1'b1;
                state_next = gkt_pkg::ST_UPD;
            end
            gkt_pkg::ST_UPD: begin
                if (!stat.upd_emits || stat.ev_ok) begin
                    cmd.key_upd = 1'b1;
                    state_next  = gkt_pkg::ST_ADV;
                end
            end
            gkt_pkg::ST_ADV: begin
                if (!stat.idx_last) begin
                    cmd.idx_inc = 1'b1;
                    state_next  = gkt_pkg::ST_SRC;
                end else if (mode_reg) begin
                    state_next = gkt_pkg::ST_SW_RD;
                end else begin
                    state_next = gkt_pkg::ST_FLUSH;
                end
            end
            gkt_pkg::ST_SW_RD: begin
                cmd.sw_rd  = 1'b1;
                state_next = gkt_pkg::ST_SW_LD;
            end
            gkt_pkg::ST_SW_LD: begin
                cmd.sw_load = 1'b1;
                state_next  = gkt_pkg::ST_SW_EM;
            end
            gkt_pkg::ST_SW_EM: begin
                if (stat.cnt_zero) begin
                    cmd.sw_next = 1'b1;
                    if (!stat.addr_last) begin
                        state_next = gkt_pkg::ST_SW_RD;
                    end else if (stat.frame_go) begin
                        cmd.idx_clr = 1'b1;
                        mode_next   = 1'b0;
                        state_next  = gkt_pkg::ST_SRC;
                    end else begin
                        state_next = gkt_pkg::ST_FLUSH;
                    end
                end else if (stat.ev_ok) begin
                    cmd.sw_step = 1'b1;
                end
            end
            gkt_pkg::ST_FLUSH: begin
                if (stat.ev_ok) begin
                    cmd.flush  = 1'b1;
                    state_next = gkt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gkt_pkg::ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

[rtl/core/gkt_checker.sv]
// Port-level checker for the translator, bound to the top level.
`default_nettype none
module gkt_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready
);
    // a pending event stays offered until taken
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("m_valid dropped before accept");

    // reset blocks input (clearing pass) and empties the output register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("block not quiet after reset");

    // one item at a time: no accept on the cycle after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item accepted back to back");
endmodule

bind gamepad_to_key_event_translator gkt_checker u_gkt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready)
);
`default_nettype wire
